// ===== src/ale_pkg.sv =====
// Shared types and constants for the array list engine.
// Holds command and status codes and the control bundle sent to the cells.
// No dependencies.
package ale_pkg;

	localparam int CAPACITY_DEF = 8;
	localparam int IDX_MAX_W = 6;
	localparam int CNT_MAX_W = 7;
	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [3:0] {
		CMD_CLEAR    = 4'd0,
		CMD_APPEND   = 4'd1,
		CMD_INS_HEAD = 4'd2,
		CMD_INS_AT   = 4'd3,
		CMD_POP_TAIL = 4'd4,
		CMD_POP_HEAD = 4'd5,
		CMD_REM_AT   = 4'd6,
		CMD_FIND     = 4'd7,
		CMD_CONTAINS = 4'd8,
		CMD_REM_VAL  = 4'd9
	} cmd_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_BAD   = 2'd3;

	typedef struct packed {
		logic                 ins;
		logic                 rem;
		logic [IDX_MAX_W-1:0] at;
		word_t                word;
	} cell_ctrl_t;

endpackage

// ===== src/ale_cell.sv =====
// One storage cell of the array list engine: holds a single entry.
// Shifts in from its left or right neighbor on insert or remove and
// compares its entry against a search word. Depends on ale_pkg.
module ale_cell #(
	parameter int INDEX = 0
) (
	input  logic                clk,
	input  ale_pkg::cell_ctrl_t ctrl,
	input  logic                cmp_en,
	input  ale_pkg::word_t      cmp_word,
	input  ale_pkg::word_t      left_word,
	input  ale_pkg::word_t      right_word,
	output ale_pkg::word_t      entry,
	output logic                match
);

	localparam logic [ale_pkg::IDX_MAX_W-1:0] MY_IDX = ale_pkg::IDX_MAX_W'(INDEX);

	ale_pkg::word_t entry_q;
	ale_pkg::word_t entry_nxt;
	logic           match_q;

	always_comb begin
		entry_nxt = entry_q;
		if (ctrl.ins) begin
			if (MY_IDX > ctrl.at) begin
				entry_nxt = left_word;
			end else if (MY_IDX == ctrl.at) begin
				entry_nxt = ctrl.word;
			end
		end
		if (ctrl.rem && (MY_IDX >= ctrl.at)) begin
			entry_nxt = right_word;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_nxt;
		if (cmp_en) begin
			match_q <= (entry_q == cmp_word);
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

// ===== src/array_list_engine_unit.sv =====
// Top level of the array list engine: a bounded ordered list of signed words.
// Instantiates a row of ale_cell storage cells and contains the command sequencer.
// Depends on ale_pkg and ale_cell.
//
// Usage: one command per input transaction on the s_ channel, one result per
// command on the m_ channel. In the accept cycle every cell compares its entry
// with the incoming value; in the S_EXEC update state the first match is
// encoded, the cells shift or load in a single step and the result is written
// to the output register. s_tready is low in S_EXEC, so this compare-then-update
// loop on the cell row takes no new command before the current one has
// updated the cells.
// A new command is taken while a finished result still waits in the output
// register; if the receiver stalls, the second command holds in its update
// cycle until the output register is free, and s_tready stays low meanwhile.
// Reset empties the list (last index -1), clears m_tvalid and raises s_tready;
// entry contents are not cleared, as only occupied entries are ever read.
module array_list_engine_unit #(
	parameter int CAPACITY = ale_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// command [3:0], value [35:4], position [39:36]
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status [1:0], last_index [5:2], found_position [8:6], found [9], zero [15:10]
	output logic [15:0] m_tdata
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMW = ale_pkg::CNT_MAX_W;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       occ_q;
	logic [CNT_W-1:0]       occ_nxt;
	logic [3:0]             cmd_q;
	ale_pkg::word_t         word_q;
	logic [3:0]             pos_q;

	logic                   accept;
	logic                   fire;
	ale_pkg::word_t         entries [CAPACITY];
	logic [CAPACITY-1:0]    match;
	logic [CAPACITY-1:0]    match_v;
	logic [CAPACITY-1:0]    lowest;
	logic [IDX_W-1:0]       where_idx;
	logic                   any_hit;
	logic                   full;
	logic                   empty;
	logic                   pos_bad;
	ale_pkg::cell_ctrl_t    ctrl;
	logic                   ins;
	logic                   rem;
	logic [ale_pkg::IDX_MAX_W-1:0] at;
	logic [1:0]             status;
	logic [2:0]             fpos;
	logic                   hit;

	logic                   m_tvalid_q;
	logic [1:0]             status_q;
	logic [3:0]             last_index_q;
	logic [2:0]             fpos_q;
	logic                   found_q;

	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign fire = (state_q == S_EXEC) && (!m_tvalid_q || m_tready);

	genvar k;
	generate
		for (k = 0; k < CAPACITY; k++) begin : g_cell
			ale_pkg::word_t left_w;
			ale_pkg::word_t right_w;
			if (k == 0) begin : g_first
				assign left_w = entries[k];
			end else begin : g_inner_l
				assign left_w = entries[k-1];
			end
			if (k == CAPACITY - 1) begin : g_last
				assign right_w = entries[k];
			end else begin : g_inner_r
				assign right_w = entries[k+1];
			end
			ale_cell #(
				.INDEX(k)
			) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.cmp_en    (accept),
				.cmp_word  (ale_pkg::word_t'(s_tdata[35:4])),
				.left_word (left_w),
				.right_word(right_w),
				.entry     (entries[k]),
				.match     (match[k])
			);
			assign match_v[k] = match[k] && (CMW'(k) < CMW'(occ_q));
		end
	endgenerate

	assign lowest = match_v & (~match_v + CAPACITY'(1));
	assign any_hit = |match_v;

	always_comb begin
		where_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (lowest[i]) begin
				where_idx = where_idx | IDX_W'(i);
			end
		end
	end

	assign full = (CMW'(occ_q) == CMW'(CAPACITY));
	assign empty = (occ_q == '0);
	assign pos_bad = (CMW'(pos_q) >= CMW'(occ_q));

	always_comb begin
		status = ale_pkg::ST_OK;
		ins = 1'b0;
		rem = 1'b0;
		at = '0;
		occ_nxt = occ_q;
		fpos = '0;
		hit = 1'b0;
		case (cmd_q)
			ale_pkg::CMD_CLEAR: begin
				occ_nxt = '0;
			end
			ale_pkg::CMD_APPEND: begin
				if (full) begin
					status = ale_pkg::ST_FULL;
				end else begin
					ins = 1'b1;
					at = ale_pkg::IDX_MAX_W'(occ_q);
					occ_nxt = occ_q + CNT_W'(1);
				end
			end
			ale_pkg::CMD_INS_HEAD: begin
				if (full) begin
					status = ale_pkg::ST_FULL;
				end else begin
					ins = 1'b1;
					occ_nxt = occ_q + CNT_W'(1);
				end
			end
			ale_pkg::CMD_INS_AT: begin
				if (full) begin
					status = ale_pkg::ST_FULL;
				end else if (pos_bad) begin
					status = ale_pkg::ST_BAD;
				end else begin
					ins = 1'b1;
					at = ale_pkg::IDX_MAX_W'(pos_q);
					occ_nxt = occ_q + CNT_W'(1);
				end
			end
			ale_pkg::CMD_POP_TAIL: begin
				if (empty) begin
					status = ale_pkg::ST_EMPTY;
				end else begin
					occ_nxt = occ_q - CNT_W'(1);
				end
			end
			ale_pkg::CMD_POP_HEAD: begin
				if (empty) begin
					status = ale_pkg::ST_EMPTY;
				end else begin
					rem = 1'b1;
					occ_nxt = occ_q - CNT_W'(1);
				end
			end
			ale_pkg::CMD_REM_AT: begin
				if (empty) begin
					status = ale_pkg::ST_EMPTY;
				end else if (pos_bad) begin
					status = ale_pkg::ST_BAD;
				end else begin
					rem = 1'b1;
					at = ale_pkg::IDX_MAX_W'(pos_q);
					occ_nxt = occ_q - CNT_W'(1);
				end
			end
			ale_pkg::CMD_FIND: begin
				if (empty) begin
					status = ale_pkg::ST_EMPTY;
				end else if (any_hit) begin
					fpos = 3'(where_idx);
					hit = 1'b1;
				end else begin
					status = ale_pkg::ST_BAD;
				end
			end
			ale_pkg::CMD_CONTAINS: begin
				if (empty) begin
					status = ale_pkg::ST_EMPTY;
				end else begin
					hit = any_hit;
				end
			end
			ale_pkg::CMD_REM_VAL: begin
				if (empty) begin
					status = ale_pkg::ST_EMPTY;
				end else if (any_hit) begin
					rem = 1'b1;
					at = ale_pkg::IDX_MAX_W'(where_idx);
					occ_nxt = occ_q - CNT_W'(1);
				end else begin
					status = ale_pkg::ST_BAD;
				end
			end
			default: begin
			end
		endcase
	end

	assign ctrl.ins = fire && ins;
	assign ctrl.rem = fire && rem;
	assign ctrl.at = at;
	assign ctrl.word = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (fire) begin
				occ_q <= occ_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= s_tdata[3:0];
			word_q <= ale_pkg::word_t'(s_tdata[35:4]);
			pos_q <= s_tdata[39:36];
		end
		if (fire) begin
			status_q <= status;
			last_index_q <= 4'(CMW'(occ_nxt) - CMW'(1));
			fpos_q <= fpos;
			found_q <= hit;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {6'd0, found_q, fpos_q, last_index_q, status_q};

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMW'(occ_q) <= CMW'(CAPACITY))
		else $error("Occupancy exceeds capacity.");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("Accepted transaction did not enter the update cycle.");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && found_q) |-> (status_q == ale_pkg::ST_OK))
		else $error("Found flag set with a failing status.");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ins) |=> (CMW'(occ_q) == CMW'($past(occ_q)) + CMW'(1)))
		else $error("Insert did not grow the list by one entry.");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for array_list_engine_unit: command transactions in, one result per command out.
// A scoreboard class keeps its own copy of the list and checks every result field.
// Depends on ale_pkg and the array_list_engine_unit RTL.
module tb;

	localparam int CAP = ale_pkg::CAPACITY_DEF;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 820;
	localparam int CALM_FROM = 720;
	localparam int HOLD_CYCLES = 60;
	localparam logic [3:0] CMD_SPARE_LO = 4'd10;
	localparam logic [3:0] CMD_SPARE_HI = 4'd15;

	typedef struct packed {
		logic [5:0] pad;
		logic       found;
		logic [2:0] fpos;
		logic [3:0] last;
		logic [1:0] status;
	} result_t;

	class list_scoreboard;
		ale_pkg::word_t cells[CAP];
		int             fill;
		result_t        pending_results[$];
		int             errors;

		function new();
			fill = 0;
			errors = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void open_slot(int at, ale_pkg::word_t w);
			for (int k = fill; k > at; k--)
				cells[k] = cells[k-1];
			cells[at] = w;
			fill++;
		endfunction

		function void close_slot(int at);
			for (int k = at; k + 1 < fill; k++)
				cells[k] = cells[k+1];
			fill--;
		endfunction

		function int locate(ale_pkg::word_t w);
			for (int k = 0; k < fill; k++)
				if (cells[k] == w)
					return k;
			return -1;
		endfunction

		function void note_command(logic [3:0] cmd, ale_pkg::word_t word,
			logic [3:0] pos);
			result_t r;
			int      where;
			bit      full;
			bit      empty;
			r = '0;
			full = (fill >= CAP);
			empty = (fill == 0);
			where = locate(word);
			case (cmd)
				ale_pkg::CMD_CLEAR: fill = 0;
				ale_pkg::CMD_APPEND: begin
					if (full) r.status = ale_pkg::ST_FULL;
					else open_slot(fill, word);
				end
				ale_pkg::CMD_INS_HEAD: begin
					if (full) r.status = ale_pkg::ST_FULL;
					else open_slot(0, word);
				end
				ale_pkg::CMD_INS_AT: begin
					if (full) r.status = ale_pkg::ST_FULL;
					else if (int'(pos) >= fill) r.status = ale_pkg::ST_BAD;
					else open_slot(int'(pos), word);
				end
				ale_pkg::CMD_POP_TAIL: begin
					if (empty) r.status = ale_pkg::ST_EMPTY;
					else fill--;
				end
				ale_pkg::CMD_POP_HEAD: begin
					if (empty) r.status = ale_pkg::ST_EMPTY;
					else close_slot(0);
				end
				ale_pkg::CMD_REM_AT: begin
					if (empty) r.status = ale_pkg::ST_EMPTY;
					else if (int'(pos) >= fill) r.status = ale_pkg::ST_BAD;
					else close_slot(int'(pos));
				end
				ale_pkg::CMD_FIND: begin
					if (empty) r.status = ale_pkg::ST_EMPTY;
					else if (where >= 0) begin
						r.fpos = 3'(where);
						r.found = 1'b1;
					end else r.status = ale_pkg::ST_BAD;
				end
				ale_pkg::CMD_CONTAINS: begin
					if (empty) r.status = ale_pkg::ST_EMPTY;
					else if (where >= 0) r.found = 1'b1;
				end
				ale_pkg::CMD_REM_VAL: begin
					if (empty) r.status = ale_pkg::ST_EMPTY;
					else if (where >= 0) close_slot(where);
					else r.status = ale_pkg::ST_BAD;
				end
				default: ;
			endcase
			r.last = 4'(fill - 1);
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [15:0] data);
			result_t got;
			result_t want;
			got = data;
			if (pending_results.size() == 0) begin
				$error("result %h arrived with no command outstanding", data);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last_index: expected %0d, got %0d", $signed(want.last),
					$signed(got.last));
				errors++;
			end
			if (got.fpos !== want.fpos) begin
				$error("found_position: expected %0d, got %0d", want.fpos, got.fpos);
				errors++;
			end
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				errors++;
			end
			if (got.pad !== want.pad) begin
				$error("zero: expected %0h, got %0h", want.pad, got.pad);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	list_scoreboard sb;
	bit             calm;
	bit             hold_req;
	int             stall_cycles;
	ale_pkg::word_t pool[6];

	array_list_engine_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic send_command(input logic [3:0] cmd, input ale_pkg::word_t word,
		input logic [3:0] pos);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {pos, word, cmd};
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, word, pos);
	endtask

	task automatic idle_sender(input int n);
		repeat (n) @(negedge clk) s_tvalid <= 1'b0;
	endtask

	task automatic drain_results();
		@(negedge clk) s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic ale_pkg::word_t pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return pool[$urandom_range(0, 5)];
			5: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("tb failed");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int cyc;
		int stall_pct;
		m_tready = 1'b0;
		cyc = 0;
		stall_pct = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (cyc % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 15;
					default: stall_pct = 40;
				endcase
			end
			cyc++;
			if (hold_req) begin
				m_tready <= 1'b0;
				hold_req = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 8)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [3:0]     cmd;
		logic [3:0]     pos;
		ale_pkg::word_t word;
		int unsigned    r;
		int             idle_pct;
		int             burst_left;
		bit             growing;
		sb = new();
		calm = 1'b0;
		hold_req = 1'b0;
		stall_cycles = 0;
		idle_pct = 0;
		burst_left = 0;
		growing = 1'b1;
		foreach (pool[k])
			pool[k] = $urandom;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty list: every removal and search reports empty, insert at is a bad position.
		send_command(ale_pkg::CMD_POP_TAIL, 32'h0, 4'd0);
		send_command(ale_pkg::CMD_POP_HEAD, 32'h0, 4'd0);
		send_command(ale_pkg::CMD_REM_AT, 32'h0, 4'd0);
		send_command(ale_pkg::CMD_FIND, 32'h0, 4'd0);
		send_command(ale_pkg::CMD_CONTAINS, 32'h0, 4'd0);
		send_command(ale_pkg::CMD_REM_VAL, 32'h0, 4'd0);
		send_command(ale_pkg::CMD_INS_AT, 32'h5, 4'd0);
		send_command(ale_pkg::CMD_APPEND, 32'h7FFF_FFFF, 4'd0);
		send_command(ale_pkg::CMD_INS_HEAD, 32'h8000_0000, 4'd0);
		send_command(ale_pkg::CMD_INS_AT, 32'h0, 4'd1);
		send_command(ale_pkg::CMD_INS_AT, 32'hFFFF_FFFF, 4'd15);
		repeat (5) send_command(ale_pkg::CMD_APPEND, $urandom, 4'd0);
		// Full list: the full status wins over a bad position.
		send_command(ale_pkg::CMD_APPEND, 32'h1, 4'd0);
		send_command(ale_pkg::CMD_INS_HEAD, 32'h2, 4'd0);
		send_command(ale_pkg::CMD_INS_AT, 32'h3, 4'd15);
		send_command(ale_pkg::CMD_FIND, 32'h0, 4'd0);
		send_command(ale_pkg::CMD_FIND, 32'h1234_5678, 4'd0);
		send_command(ale_pkg::CMD_CONTAINS, 32'h8000_0000, 4'd0);
		send_command(ale_pkg::CMD_CONTAINS, 32'h1234_5678, 4'd0);
		send_command(ale_pkg::CMD_REM_VAL, 32'h7FFF_FFFF, 4'd0);
		send_command(ale_pkg::CMD_REM_VAL, 32'h1234_5678, 4'd0);
		send_command(ale_pkg::CMD_REM_AT, 32'h0, 4'd15);
		send_command(ale_pkg::CMD_REM_AT, 32'h0, 4'd0);
		send_command(CMD_SPARE_LO, 32'hFFFF_FFFF, 4'd15);
		send_command(CMD_SPARE_HI, 32'h0, 4'd0);
		send_command(ale_pkg::CMD_CLEAR, 32'h0, 4'd0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0)
				growing = !growing;
			if (i % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 20;
					default: idle_pct = 50;
				endcase
			end
			if (i == CALM_FROM)
				calm = 1'b1;
			if (i == 250 || i == 400) begin
				hold_req = 1'b1;
				burst_left = 12;
			end
			if (i == 450 || i == 600)
				drain_results();

			r = $urandom_range(0, 99);
			if (r < 2)
				cmd = ale_pkg::CMD_CLEAR;
			else if (r < 5)
				cmd = 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
			else if (r < (growing ? 60 : 30))
				cmd = 4'($urandom_range(ale_pkg::CMD_APPEND, ale_pkg::CMD_INS_AT));
			else
				cmd = 4'($urandom_range(ale_pkg::CMD_POP_TAIL, ale_pkg::CMD_REM_VAL));
			word = pick_value();
			if ($urandom_range(0, 4) == 0 || sb.fill == 0)
				pos = 4'($urandom_range(0, 15));
			else
				pos = 4'($urandom_range(0, sb.fill - 1));

			if (burst_left > 0)
				burst_left--;
			else if (!calm && $urandom_range(0, 99) < idle_pct)
				idle_sender($urandom_range(1, 9));
			send_command(cmd, word, pos);
		end

		@(negedge clk) s_tvalid <= 1'b0;
		drain_results();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
